@@ src/text_glyph_rasterizer_defines.svh @@
// assertion macros for the text glyph rasterizer
// expects clk and rst_n in the scope where a macro is used
`ifndef TEXT_GLYPH_RASTERIZER_DEFINES_SVH
`define TEXT_GLYPH_RASTERIZER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define TGR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define TGR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tgr_pkg.sv @@
// shared types, constants and font tables for the text glyph rasterizer
// no dependencies
`default_nettype none

package tgr_pkg;

    localparam int CHAR_W     = 8;
    localparam int XY_W       = 11;
    localparam int EDGE_W     = 12;
    localparam int ACC_W      = 13;
    localparam int SIZE_W     = 5;
    localparam int SCALE_W    = 4;
    localparam int PAL_W      = 3;
    localparam int COLOR_W    = 16;
    localparam int COL_W      = 3;
    localparam int FONT_BITS  = 28;
    localparam int FONT_IDX_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int ADV_W      = 7;

    localparam logic [XY_W-1:0]    XY_MAX     = 11'd2047;
    localparam logic [COLOR_W-1:0] BLACK_5551 = 16'h0001;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP     = 2'd3;

    // glyph indexes with special meaning
    localparam logic [FONT_IDX_W-1:0] GLYPH_A     = 6'h0A;
    localparam logic [FONT_IDX_W-1:0] GLYPH_DOT   = 6'h24;
    localparam logic [FONT_IDX_W-1:0] GLYPH_COLON = 6'h25;
    localparam logic [FONT_IDX_W-1:0] GLYPH_DASH  = 6'h26;
    localparam logic [FONT_IDX_W-1:0] GLYPH_SPACE = 6'h27;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XINIT,
        ST_YINIT,
        ST_EMIT,
        ST_ADV
    } tgr_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_X_INIT,
        OP_Y_INIT,
        OP_STEP_X,
        OP_STEP_Y,
        OP_ADVANCE
    } tgr_op_t;

    // sequencer to datapath control
    typedef struct packed {
        tgr_op_t op;
        logic    outline;
        logic    load_cursor;
    } tgr_ctrl_t;

    typedef struct packed {
        logic [COL_W-1:0]     width;
        logic [FONT_BITS-1:0] bits;
    } tgr_glyph_t;

    // character code to font index
    function automatic logic [FONT_IDX_W-1:0] glyph_of(input logic [CHAR_W-1:0] c);
        logic [FONT_IDX_W-1:0] g;
        g = GLYPH_SPACE;
        if (c >= 8'h61 && c <= 8'h7A) g = FONT_IDX_W'(c - 8'h61) + GLYPH_A;
        else if (c >= 8'h41 && c <= 8'h5A) g = FONT_IDX_W'(c - 8'h41) + GLYPH_A;
        else if (c >= 8'h30 && c <= 8'h39) g = FONT_IDX_W'(c - 8'h30);
        else if (c == 8'h2E) g = GLYPH_DOT;
        else if (c == 8'h3A) g = GLYPH_COLON;
        else if (c == 8'h2D) g = GLYPH_DASH;
        return g;
    endfunction

    // font: cell width and bitmap, first cell in the top bit
    function automatic tgr_glyph_t font_entry(input logic [FONT_IDX_W-1:0] g);
        tgr_glyph_t e;
        case (g)
            6'd0:  e = '{3'd3, 28'hF6DE000};
            6'd1:  e = '{3'd1, 28'hF800000};
            6'd2:  e = '{3'd3, 28'hC4AE000};
            6'd3:  e = '{3'd3, 28'hE59E000};
            6'd4:  e = '{3'd4, 28'h88AF200};
            6'd5:  e = '{3'd3, 28'hF39E000};
            6'd6:  e = '{3'd3, 28'hF3DE000};
            6'd7:  e = '{3'd3, 28'hE4A4000};
            6'd8:  e = '{3'd3, 28'hF7DE000};
            6'd9:  e = '{3'd3, 28'hF79E000};
            6'd10: e = '{3'd3, 28'hF6FA000};
            6'd11: e = '{3'd3, 28'hD75C000};
            6'd12: e = '{3'd3, 28'hF24E000};
            6'd13: e = '{3'd3, 28'hD6DC000};
            6'd14: e = '{3'd3, 28'hF34E000};
            6'd15: e = '{3'd3, 28'hF348000};
            6'd16: e = '{3'd3, 28'hF25E000};
            6'd17: e = '{3'd3, 28'hB7DA000};
            6'd18: e = '{3'd3, 28'hE92E000};
            6'd19: e = '{3'd3, 28'hE928000};
            6'd20: e = '{3'd3, 28'hB75A000};
            6'd21: e = '{3'd3, 28'h924E000};
            6'd22: e = '{3'd5, 28'h8EEB188};
            6'd23: e = '{3'd4, 28'h9DFB900};
            6'd24: e = '{3'd4, 28'h6999600};
            6'd25: e = '{3'd3, 28'hF7C8000};
            6'd26: e = '{3'd4, 28'h69DB700};
            6'd27: e = '{3'd3, 28'hF7EA000};
            6'd28: e = '{3'd3, 28'hF39E000};
            6'd29: e = '{3'd3, 28'hE924000};
            6'd30: e = '{3'd4, 28'h9999600};
            6'd31: e = '{3'd5, 28'h8C62A20};
            6'd32: e = '{3'd5, 28'h8C63550};
            6'd33: e = '{3'd3, 28'hB55A000};
            6'd34: e = '{3'd3, 28'hB79E000};
            6'd35: e = '{3'd4, 28'hF124F00};
            6'd36: e = '{3'd1, 28'h0800000};
            6'd37: e = '{3'd1, 28'h5000000};
            6'd38: e = '{3'd3, 28'h0380000};
            default: e = '{3'd2, 28'h0000000};
        endcase
        return e;
    endfunction

    // palette select to RGBA5551 ink colour
    function automatic logic [COLOR_W-1:0] ink_of(input logic [PAL_W-1:0] p);
        logic [COLOR_W-1:0] c;
        case (p)
            3'd0:    c = 16'h07C1;
            3'd1:    c = 16'h07FF;
            3'd2:    c = 16'hFFC1;
            3'd3:    c = 16'hF83F;
            3'd4:    c = 16'hF801;
            3'd5:    c = 16'hFC01;
            3'd6:    c = 16'hFFFF;
            default: c = 16'hF801;
        endcase
        return c;
    endfunction

    // clamp a coordinate at the top of the screen range
    function automatic logic [EDGE_W-1:0] sat_edge(input logic signed [ACC_W-1:0] v);
        logic [EDGE_W-1:0] r;
        if (v > $signed({2'b00, XY_MAX})) r = {1'b0, XY_MAX};
        else r = v[EDGE_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/tgr_if.sv @@
// request channel interfaces: character input, rectangle output, configuration writes
// depends on tgr_pkg
`default_nettype none

interface tgr_char_if;
    logic                        valid;
    logic                        ready;
    logic [tgr_pkg::CHAR_W-1:0]  char_code;
    logic                        line_start;
    modport source (output valid, char_code, line_start, input ready);
    modport sink (input valid, char_code, line_start, output ready);
endinterface

interface tgr_rect_if;
    logic                               valid;
    logic                               ready;
    logic signed [tgr_pkg::EDGE_W-1:0]  rect_x;
    logic signed [tgr_pkg::EDGE_W-1:0]  rect_y;
    logic [tgr_pkg::SIZE_W-1:0]         rect_w;
    logic [tgr_pkg::SIZE_W-1:0]         rect_h;
    logic [tgr_pkg::COLOR_W-1:0]        fill_color;
    logic                               last_rect;
    modport source (output valid, rect_x, rect_y, rect_w, rect_h, fill_color, last_rect,
                    input ready);
    modport sink (input valid, rect_x, rect_y, rect_w, rect_h, fill_color, last_rect,
                  output ready);
endinterface

interface tgr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tgr_pkg::CFG_IDX_W-1:0]    index;
    logic [tgr_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/tgr_seq.sv @@
// sequencer: walks passes, rows and cells of one glyph and drives the shared adder
// depends on tgr_pkg and text_glyph_rasterizer_defines.svh
`default_nettype none
`include "text_glyph_rasterizer_defines.svh"

module tgr_seq #(
    parameter int GLYPH_ROWS  = 5,
    parameter int FONT_GLYPHS = 40
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tgr_pkg::CHAR_W-1:0]       char_code,
    input  logic                             line_start,
    input  logic                             out_free,
    output logic                             emit,
    output logic                             cell_set,
    output logic                             last_rect,
    output logic                             outline,
    output logic [tgr_pkg::COL_W-1:0]        glyph_width,
    output tgr_pkg::tgr_ctrl_t               ctrl
);
    import tgr_pkg::*;

    localparam int GI_W  = $clog2(FONT_GLYPHS);
    localparam int ROW_W = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

    tgr_state_t             state_reg, state_next;
    logic [GI_W-1:0]        glyph_reg, glyph_next;
    logic                   pass_reg, pass_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [FONT_BITS-1:0]   bits_reg, bits_next;
    tgr_glyph_t             entry;
    logic                   last_col;
    logic                   last_row;

    // current glyph from the font table
    assign entry       = font_entry(FONT_IDX_W'(glyph_reg));
    assign glyph_width = entry.width;
    assign last_col    = (col_reg == (entry.width - 3'd1));
    assign last_row    = (row_reg == ROW_W'(GLYPH_ROWS - 1));
    assign cell_set    = bits_reg[FONT_BITS-1];
    assign outline     = !pass_reg;
    assign last_rect   = pass_reg && last_col && last_row;

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    // glyph index and cell bitmap
    always_ff @(posedge clk)
    begin
        glyph_reg <= glyph_next;
        bits_reg  <= bits_next;
    end

    // next state and control
    always_comb
    begin
        state_next       = state_reg;
        glyph_next       = glyph_reg;
        pass_next        = pass_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        bits_next        = bits_reg;
        in_ready         = 1'b0;
        emit             = 1'b0;
        ctrl.op          = OP_NONE;
        ctrl.outline     = !pass_reg;
        ctrl.load_cursor = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    glyph_next       = GI_W'(glyph_of(char_code));
                    pass_next        = 1'b0;
                    ctrl.load_cursor = line_start;
                    state_next       = ST_XINIT;
                end
            end
            ST_XINIT:
            begin
                ctrl.op    = OP_X_INIT;
                state_next = ST_YINIT;
            end
            ST_YINIT:
            begin
                ctrl.op    = OP_Y_INIT;
                row_next   = '0;
                col_next   = '0;
                bits_next  = entry.bits;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    bits_next = {bits_reg[FONT_BITS-2:0], 1'b0};
                    if (last_col)
                    begin
                        col_next = '0;
                        ctrl.op  = OP_STEP_Y;
                        if (last_row)
                        begin
                            if (!pass_reg)
                            begin
                                pass_next  = 1'b1;
                                state_next = ST_XINIT;
                            end
                            else
                            begin
                                state_next = ST_ADV;
                            end
                        end
                        else
                        begin
                            row_next = row_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                        ctrl.op  = OP_STEP_X;
                    end
                end
            end
            ST_ADV:
            begin
                ctrl.op    = OP_ADVANCE;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencing checks
    `TGR_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == ST_XINIT && !pass_reg, "accepted character did not start the outline pass")
    `TGR_ASSERT_NEXT(a_last_to_adv, emit && last_rect, state_reg == ST_ADV, "final rectangle not followed by cursor advance")
    `TGR_ASSERT_NEXT(a_pass_switch, emit && last_col && last_row && !pass_reg, state_reg == ST_XINIT && pass_reg, "outline pass did not hand over to colour pass")
    `TGR_ASSERT_SAME(a_col_in_glyph, state_reg == ST_EMIT, col_reg < glyph_width, "cell column beyond glyph width")

endmodule

`default_nettype wire

@@ src/tgr_dpath.sv @@
// datapath: cursor and edge accumulators around one shared adder
// depends on tgr_pkg
`default_nettype none

module tgr_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tgr_pkg::tgr_ctrl_t                ctrl,
    input  logic [tgr_pkg::XY_W-1:0]          line_left,
    input  logic [tgr_pkg::XY_W-1:0]          line_top,
    input  logic [tgr_pkg::SCALE_W-1:0]       scale,
    input  logic [tgr_pkg::COL_W-1:0]         glyph_width,
    output logic [tgr_pkg::EDGE_W-1:0]        rect_x,
    output logic [tgr_pkg::EDGE_W-1:0]        rect_y
);
    import tgr_pkg::*;

    logic [XY_W-1:0]           cursor_reg, cursor_next;
    logic signed [ACC_W-1:0]   x_acc_reg, x_acc_next;
    logic signed [ACC_W-1:0]   x_start_reg, x_start_next;
    logic signed [ACC_W-1:0]   y_acc_reg, y_acc_next;
    logic signed [ACC_W-1:0]   op_a, op_b, sum, offset;
    logic [ADV_W-1:0]          span;
    logic [ADV_W-1:0]          adv_amt;

    // advance amount: glyph width times scale plus gap
    assign span    = ADV_W'(glyph_width) * ADV_W'(scale);
    assign adv_amt = span + ADV_W'(2);
    assign offset  = ctrl.outline ? -13'sd1 : 13'sd0;

    // shared adder operand selection
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (ctrl.op)
            OP_X_INIT:
            begin
                op_a = $signed({2'b00, cursor_reg});
                op_b = offset;
            end
            OP_Y_INIT:
            begin
                op_a = $signed({2'b00, line_top});
                op_b = offset;
            end
            OP_STEP_X:
            begin
                op_a = x_acc_reg;
                op_b = $signed({{(ACC_W-SCALE_W){1'b0}}, scale});
            end
            OP_STEP_Y:
            begin
                op_a = y_acc_reg;
                op_b = $signed({{(ACC_W-SCALE_W){1'b0}}, scale});
            end
            OP_ADVANCE:
            begin
                op_a = $signed({2'b00, cursor_reg});
                op_b = $signed({{(ACC_W-ADV_W){1'b0}}, adv_amt});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        sum = op_a + op_b;
    end

    // register updates from the adder
    always_comb
    begin
        cursor_next  = cursor_reg;
        x_acc_next   = x_acc_reg;
        x_start_next = x_start_reg;
        y_acc_next   = y_acc_reg;
        if (ctrl.load_cursor)
        begin
            cursor_next = line_left;
        end
        case (ctrl.op)
            OP_X_INIT:
            begin
                x_acc_next   = sum;
                x_start_next = sum;
            end
            OP_Y_INIT:
            begin
                y_acc_next = sum;
            end
            OP_STEP_X:
            begin
                x_acc_next = sum;
            end
            OP_STEP_Y:
            begin
                y_acc_next = sum;
                x_acc_next = x_start_reg;
            end
            OP_ADVANCE:
            begin
                if (sum > $signed({2'b00, XY_MAX})) cursor_next = XY_MAX;
                else cursor_next = sum[XY_W-1:0];
            end
            default:
            begin
                cursor_next = cursor_next;
            end
        endcase
    end

    // cursor position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
        end
    end

    // edge accumulators
    always_ff @(posedge clk)
    begin
        x_acc_reg   <= x_acc_next;
        x_start_reg <= x_start_next;
        y_acc_reg   <= y_acc_next;
    end

    assign rect_x = sat_edge(x_acc_reg);
    assign rect_y = sat_edge(y_acc_reg);

endmodule

`default_nettype wire

@@ src/text_glyph_rasterizer.sv @@
// Text glyph rasterizer top level: one character request in, fill-rectangle requests out.
//
// char_in carries char_code and line_start; line_start reloads the cursor from
// line_left before the character is drawn. rect_out carries one rectangle per
// request: rect_x, rect_y (two's complement), rect_w, rect_h, fill_color
// (RGBA5551) and last_rect, set on the final rectangle of the character.
// cfg writes palette_select (0), glyph_scale (1), line_left (2) and line_top (3);
// it is always ready and is meant to be written while no character is in flight.
//
// Each character makes two passes of W*R rectangles (W glyph cells wide, R rows):
// a black outline pass and a colour pass. The sequencer issues one rectangle per
// cycle while the receiver keeps up, through a single shared adder, with x and y
// set-up states before each pass, one accept state and one cursor advance state.
// char_in is ready only between characters. The first rectangle follows accept
// through the x and y set-up states, the emit state and the output register.
// A stalled receiver holds the output register and freezes the sequencer.
// Reset clears the cursor to 0 and loads the register defaults: palette 0,
// scale 2, line_left 14, line_top 10.
// depends on tgr_pkg, tgr_if, tgr_seq and tgr_dpath
`default_nettype none

module text_glyph_rasterizer #(
    parameter int GLYPH_ROWS  = 5,
    parameter int FONT_GLYPHS = 40
) (
    input  logic           clk,
    input  logic           rst_n,
    tgr_char_if.sink       char_in,
    tgr_rect_if.source     rect_out,
    tgr_cfg_if.sink        cfg
);
    import tgr_pkg::*;

    logic [PAL_W-1:0]     palette_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic [XY_W-1:0]      left_reg;
    logic [XY_W-1:0]      top_reg;
    logic [SCALE_W-1:0]   scale_eff;

    logic                 out_valid_reg;
    logic [EDGE_W-1:0]    out_x_reg;
    logic [EDGE_W-1:0]    out_y_reg;
    logic [SIZE_W-1:0]    out_w_reg;
    logic [SIZE_W-1:0]    out_h_reg;
    logic [COLOR_W-1:0]   out_color_reg;
    logic                 out_last_reg;

    logic                 out_free;
    logic                 emit;
    logic                 cell_set;
    logic                 last_rect;
    logic                 outline;
    logic [COL_W-1:0]     glyph_width;
    tgr_ctrl_t            ctrl;
    logic [EDGE_W-1:0]    edge_x;
    logic [EDGE_W-1:0]    edge_y;
    logic [SIZE_W-1:0]    rect_size;

    // a zero scale draws as one
    assign scale_eff = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_reg <= '0;
            scale_reg   <= SCALE_W'(2);
            left_reg    <= XY_W'(14);
            top_reg     <= XY_W'(10);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PALETTE: palette_reg <= cfg.data[PAL_W-1:0];
                REG_SCALE:   scale_reg   <= cfg.data[SCALE_W-1:0];
                REG_LEFT:    left_reg    <= cfg.data[XY_W-1:0];
                REG_TOP:     top_reg     <= cfg.data[XY_W-1:0];
                default:     palette_reg <= palette_reg;
            endcase
        end
    end

    // sequencer
    tgr_seq #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .FONT_GLYPHS (FONT_GLYPHS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (char_in.valid),
        .in_ready    (char_in.ready),
        .char_code   (char_in.char_code),
        .line_start  (char_in.line_start),
        .out_free    (out_free),
        .emit        (emit),
        .cell_set    (cell_set),
        .last_rect   (last_rect),
        .outline     (outline),
        .glyph_width (glyph_width),
        .ctrl        (ctrl)
    );

    // cursor and edge datapath
    tgr_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .line_left   (left_reg),
        .line_top    (top_reg),
        .scale       (scale_eff),
        .glyph_width (glyph_width),
        .rect_x      (edge_x),
        .rect_y      (edge_y)
    );

    // output register
    assign out_free  = !out_valid_reg || rect_out.ready;
    assign rect_size = SIZE_W'(scale_eff) + (outline ? SIZE_W'(2) : SIZE_W'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg     <= edge_x;
            out_y_reg     <= edge_y;
            out_w_reg     <= rect_size;
            out_h_reg     <= rect_size;
            out_color_reg <= (!outline && cell_set) ? ink_of(palette_reg) : BLACK_5551;
            out_last_reg  <= last_rect;
        end
    end

    assign rect_out.valid      = out_valid_reg;
    assign rect_out.rect_x     = $signed(out_x_reg);
    assign rect_out.rect_y     = $signed(out_y_reg);
    assign rect_out.rect_w     = out_w_reg;
    assign rect_out.rect_h     = out_h_reg;
    assign rect_out.fill_color = out_color_reg;
    assign rect_out.last_rect  = out_last_reg;

endmodule

`default_nettype wire
